// File: design/lfrc_pkg.sv
// Shared types, codes and constants of the line-follow route controller.
// Holds the route table and the small helper functions used by the step logic.
// No dependencies.
package lfrc_pkg;

  // Default number of stored routes.
  localparam int unsigned ROUTE_COUNT_DEF = 5;

  // Depth of the result queue.
  localparam int unsigned RES_FIFO_DEPTH = 4;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Input opcodes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Navigation status codes.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_NAV     = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_ARRIVED = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  // Event codes.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_STOPPED  = 3'd2;
  localparam logic [2:0] EV_OBSTACLE = 3'd3;
  localparam logic [2:0] EV_REACHED  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CORRECTION = 3'd5;

  // Configuration reset values.
  localparam logic [11:0] THRESHOLD_RST  = 12'd200;
  localparam logic [9:0]  MARGIN_RST     = 10'd80;
  localparam logic [9:0]  INTERVAL_RST   = 10'd20;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd1000;
  localparam logic [7:0]  BASE_RST       = 8'd180;
  localparam logic [6:0]  CORRECTION_RST = 7'd50;

  // Turn codes held in the route table.
  localparam logic [2:0] TURN_LEFT  = 3'd1;
  localparam logic [2:0] TURN_RIGHT = 3'd2;
  localparam logic [2:0] TURN_UTURN = 3'd3;

  // Turn drives and durations.
  localparam logic signed [8:0] SPIN_DRIVE  = 9'sd200;
  localparam logic signed [8:0] UTURN_DRIVE = 9'sd220;
  localparam logic [9:0]        SPIN_MS     = 10'd400;
  localparam logic [9:0]        UTURN_MS    = 10'd850;
  localparam logic [9:0]        STRAIGHT_MS = 10'd200;

  // Slow-down applied when no sensor sees the line.
  localparam logic signed [10:0] SEARCH_SLOWDOWN = 11'sd30;

  // Drive limits.
  localparam logic signed [10:0] DRIVE_MAX = 11'sd255;
  localparam logic signed [10:0] DRIVE_MIN = -11'sd255;

  // Configuration register set.
  typedef struct packed {
    logic [11:0] threshold;
    logic [9:0]  margin;
    logic [9:0]  interval;
    logic [15:0] debounce;
    logic [7:0]  base;
    logic [6:0]  correction;
  } cfg_t;

  // One accepted input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  route;
    logic [31:0] now_ms;
    logic [11:0] distance_mm;
    logic        line_left;
    logic        line_center_left;
    logic        line_center_right;
    logic        line_right;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]        status;
    logic signed [8:0] left_drive;
    logic signed [8:0] right_drive;
    logic              turning;
    logic [2:0]        event_res;
    logic [2:0]        event_route;
    logic              start_ok;
    logic              last;
  } res_t;

  // Route table: bits 1:0 junction count, then three 3-bit turn codes.
  function automatic logic [10:0] route_word(input logic [2:0] idx);
    logic [10:0] w;
    unique case (idx)
      3'd0:    w = 11'd5;
      3'd1:    w = 11'd34;
      3'd2:    w = 11'd66;
      3'd3:    w = 11'd267;
      3'd4:    w = 11'd14;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  // Turn code for the junction just counted; the fields repeat every three junctions.
  function automatic logic [2:0] turn_code(input logic [10:0] word, input logic [2:0] jp);
    logic [2:0] code;
    unique case (jp)
      3'd2, 3'd5: code = word[7:5];
      3'd3, 3'd6: code = word[10:8];
      default:    code = word[4:2];
    endcase
    return code;
  endfunction

  // Clamp a widened drive value to the motor range.
  function automatic logic signed [8:0] sat_drive(input logic signed [10:0] v);
    logic signed [8:0] r;
    if (v > DRIVE_MAX) begin
      r = DRIVE_MAX[8:0];
    end else if (v < DRIVE_MIN) begin
      r = DRIVE_MIN[8:0];
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

endpackage

// File: design/line_follow_route_controller_core.sv
// Top level of the line-follow route controller.
// Depends on lfrc_pkg, lfrc_cfg_regs, lfrc_step and lfrc_res_fifo.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o): one item per transfer, a tick, a
//    route start, a cancel or a no-op. The item lands in an input register.
//  - Output channel (out_valid_o / out_ready_i): one result per transfer. Most items
//    give one result; arrival at the route's last junction gives two, the second
//    marked with last_o.
//  - Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i at once.
//    Write only while no item is in flight.
// Timing: an item is evaluated from the input register by single-pass logic once the
//  result queue has room, and its results go into the result queue, from which the
//  first result is handed out. One item is taken every cycle while the
//  four-entry result queue has two free places; an arrival adds one extra result.
// Reset: configuration returns to its default values, navigation goes idle with no
//  route, and the input register and result queue are empty.
// Stall: when the receiver holds out_ready_i low, results wait in the queue and input
//  is refused once fewer than two places are free.
module line_follow_route_controller_core
  import lfrc_pkg::*;
#(
  parameter int unsigned ROUTE_COUNT = ROUTE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [2:0]            route_i,
  input  logic [31:0]           now_ms_i,
  input  logic [11:0]           distance_mm_i,
  input  logic                  line_left_i,
  input  logic                  line_center_left_i,
  input  logic                  line_center_right_i,
  input  logic                  line_right_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic signed [8:0]     left_drive_o,
  output logic signed [8:0]     right_drive_o,
  output logic                  turning_o,
  output logic [2:0]            event_res_o,
  output logic [2:0]            event_route_o,
  output logic                  start_ok_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  logic  room;
  logic  fire;
  res_t  res0, res1, res_out;
  logic  two;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  // Input register: refilled on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode            <= opcode_i;
      item_q.route             <= route_i;
      item_q.now_ms            <= now_ms_i;
      item_q.distance_mm       <= distance_mm_i;
      item_q.line_left         <= line_left_i;
      item_q.line_center_left  <= line_center_left_i;
      item_q.line_center_right <= line_center_right_i;
      item_q.line_right        <= line_right_i;
    end
  end

  lfrc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lfrc_step #(
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res0_o (res0),
    .res1_o (res1),
    .two_o  (two)
  );

  lfrc_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_two_i  (two),
    .d0_i        (res0),
    .d1_i        (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res_out)
  );

  // Result fields onto their ports.
  assign status_o      = res_out.status;
  assign left_drive_o  = res_out.left_drive;
  assign right_drive_o = res_out.right_drive;
  assign turning_o     = res_out.turning;
  assign event_res_o   = res_out.event_res;
  assign event_route_o = res_out.event_route;
  assign start_ok_o    = res_out.start_ok;
  assign last_o        = res_out.last;

endmodule

// File: design/lfrc_cfg_regs.sv
// Configuration register file of the line-follow route controller.
// Depends on lfrc_pkg for the register indexes, reset values and cfg_t.
module lfrc_cfg_regs
  import lfrc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Each write updates one register; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.margin     <= MARGIN_RST;
      cfg_q.interval   <= INTERVAL_RST;
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.base       <= BASE_RST;
      cfg_q.correction <= CORRECTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_THRESHOLD:  cfg_q.threshold  <= cfg_wdata_i[11:0];
        CFG_MARGIN:     cfg_q.margin     <= cfg_wdata_i[9:0];
        CFG_INTERVAL:   cfg_q.interval   <= cfg_wdata_i[9:0];
        CFG_DEBOUNCE:   cfg_q.debounce   <= cfg_wdata_i[15:0];
        CFG_BASE:       cfg_q.base       <= cfg_wdata_i[7:0];
        CFG_CORRECTION: cfg_q.correction <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/lfrc_step.sv
// Navigation state and single-pass update logic of the line-follow route controller.
// Depends on lfrc_pkg for codes, the route table and the item, result and config types.
module lfrc_step
  import lfrc_pkg::*;
#(
  parameter int unsigned ROUTE_COUNT = ROUTE_COUNT_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res0_o,
  output res_t  res1_o,
  output logic  two_o
);

  localparam logic [3:0] ROUTE_LIMIT = 4'(ROUTE_COUNT);

  logic [2:0]        nav_q, nav_d;
  logic [2:0]        route_q, route_d;
  logic              route_valid_q, route_valid_d;
  logic [2:0]        jp_q, jp_d;
  logic [31:0]       last_junc_q, last_junc_d;
  logic              turn_q, turn_d;
  logic [31:0]       turn_begin_q, turn_begin_d;
  logic [9:0]        turn_len_q, turn_len_d;
  logic [31:0]       last_tick_q, last_tick_d;
  logic signed [8:0] dl_q, dl_d;
  logic signed [8:0] dr_q, dr_d;

  logic [31:0]        tick_gap, turn_gap, junc_gap;
  logic [12:0]        clear_level;
  logic [10:0]        word;
  logic [2:0]         jp_inc;
  logic               junction_seen;
  logic               turn_done;
  logic signed [10:0] b, c;
  logic [2:0]         ev0;
  logic               ok0;
  logic               two;

  assign tick_gap      = item_i.now_ms - last_tick_q;
  assign turn_gap      = item_i.now_ms - turn_begin_q;
  assign junc_gap      = item_i.now_ms - last_junc_q;
  assign clear_level   = {1'b0, cfg_i.threshold} + {3'b000, cfg_i.margin};
  assign word          = route_word(route_q);
  assign jp_inc        = (jp_q == 3'd7) ? jp_q : jp_q + 3'd1;
  assign junction_seen = item_i.line_left && item_i.line_right &&
                         (item_i.line_center_left || item_i.line_center_right);
  assign turn_done     = !turn_q || (turn_gap >= {22'd0, turn_len_q});
  assign b             = signed'({3'b000, cfg_i.base});
  assign c             = signed'({4'b0000, cfg_i.correction});

  // Next state and events for the item in the input register.
  always_comb begin
    nav_d         = nav_q;
    route_d       = route_q;
    route_valid_d = route_valid_q;
    jp_d          = jp_q;
    last_junc_d   = last_junc_q;
    turn_d        = turn_q;
    turn_begin_d  = turn_begin_q;
    turn_len_d    = turn_len_q;
    last_tick_d   = last_tick_q;
    dl_d          = dl_q;
    dr_d          = dr_q;
    ev0           = EV_NONE;
    ok0           = 1'b0;
    two           = 1'b0;

    unique case (item_i.opcode)
      OP_TICK: begin
        // Ticks inside the loop interval leave everything as it is.
        if (tick_gap >= {22'd0, cfg_i.interval}) begin
          last_tick_d = item_i.now_ms;
          if (item_i.distance_mm < cfg_i.threshold) begin
            // Obstacle: halt, and report it only on entry to blocked.
            if (nav_q != ST_BLOCKED) begin
              turn_d = 1'b0;
              dl_d   = '0;
              dr_d   = '0;
              nav_d  = ST_BLOCKED;
              ev0    = EV_OBSTACLE;
            end
          end else begin
            if (nav_q == ST_BLOCKED && {1'b0, item_i.distance_mm} >= clear_level) begin
              nav_d = ST_NAV;
            end
            if (nav_d == ST_NAV && route_valid_q && turn_done) begin
              turn_d = 1'b0;
              if (junction_seen && junc_gap >= {16'd0, cfg_i.debounce}) begin
                last_junc_d = item_i.now_ms;
                jp_d        = jp_inc;
                if (jp_inc >= {1'b0, word[1:0]}) begin
                  // Last junction of the route: stop and report arrival.
                  dl_d  = '0;
                  dr_d  = '0;
                  nav_d = ST_ARRIVED;
                  ev0   = EV_REACHED;
                  two   = 1'b1;
                end else begin
                  // Start the timed turn that the route gives for this junction.
                  turn_d       = 1'b1;
                  turn_begin_d = item_i.now_ms;
                  unique case (turn_code(word, jp_inc))
                    TURN_LEFT: begin
                      dl_d       = -SPIN_DRIVE;
                      dr_d       = SPIN_DRIVE;
                      turn_len_d = SPIN_MS;
                    end
                    TURN_RIGHT: begin
                      dl_d       = SPIN_DRIVE;
                      dr_d       = -SPIN_DRIVE;
                      turn_len_d = SPIN_MS;
                    end
                    TURN_UTURN: begin
                      dl_d       = -UTURN_DRIVE;
                      dr_d       = UTURN_DRIVE;
                      turn_len_d = UTURN_MS;
                    end
                    default: begin
                      dl_d       = signed'({1'b0, cfg_i.base});
                      dr_d       = signed'({1'b0, cfg_i.base});
                      turn_len_d = STRAIGHT_MS;
                    end
                  endcase
                end
              end else begin
                // Differential steering from the line sensors.
                priority if (item_i.line_center_left && item_i.line_center_right) begin
                  dl_d = sat_drive(b);
                  dr_d = sat_drive(b);
                end else if (item_i.line_center_left) begin
                  dl_d = sat_drive(b - c);
                  dr_d = sat_drive(b + c);
                end else if (item_i.line_center_right) begin
                  dl_d = sat_drive(b + c);
                  dr_d = sat_drive(b - c);
                end else if (item_i.line_left && !item_i.line_right) begin
                  dl_d = sat_drive(b - (c <<< 1));
                  dr_d = sat_drive(b + c);
                end else if (item_i.line_right && !item_i.line_left) begin
                  dl_d = sat_drive(b + c);
                  dr_d = sat_drive(b - (c <<< 1));
                end else begin
                  dl_d = sat_drive(b - SEARCH_SLOWDOWN);
                  dr_d = sat_drive(b - SEARCH_SLOWDOWN);
                end
              end
            end
          end
        end
      end
      OP_START: begin
        if ({1'b0, item_i.route} >= ROUTE_LIMIT) begin
          nav_d = ST_ERROR;
        end else begin
          turn_d        = 1'b0;
          route_d       = item_i.route;
          route_valid_d = 1'b1;
          jp_d          = '0;
          last_junc_d   = item_i.now_ms;
          nav_d         = ST_NAV;
          ev0           = EV_STARTED;
          ok0           = 1'b1;
        end
      end
      OP_CANCEL: begin
        turn_d = 1'b0;
        dl_d   = '0;
        dr_d   = '0;
        nav_d  = ST_IDLE;
        ev0    = EV_STOPPED;
      end
      default: ;
    endcase
  end

  // Results reflect the state after the update.
  always_comb begin
    res0_o.status      = nav_d;
    res0_o.left_drive  = dl_d;
    res0_o.right_drive = dr_d;
    res0_o.turning     = turn_d;
    res0_o.event_res   = ev0;
    res0_o.event_route = (ev0 == EV_NONE) ? 3'd0 : route_d;
    res0_o.start_ok    = ok0;
    res0_o.last        = !two;

    res1_o             = res0_o;
    res1_o.event_res   = EV_STOPPED;
    res1_o.event_route = route_d;
    res1_o.last        = 1'b1;
  end

  assign two_o = two;

  // State registers, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nav_q         <= ST_IDLE;
      route_q       <= '0;
      route_valid_q <= 1'b0;
      jp_q          <= '0;
      last_junc_q   <= '0;
      turn_q        <= 1'b0;
      turn_begin_q  <= '0;
      turn_len_q    <= '0;
      last_tick_q   <= '0;
      dl_q          <= '0;
      dr_q          <= '0;
    end else if (fire_i) begin
      nav_q         <= nav_d;
      route_q       <= route_d;
      route_valid_q <= route_valid_d;
      jp_q          <= jp_d;
      last_junc_q   <= last_junc_d;
      turn_q        <= turn_d;
      turn_begin_q  <= turn_begin_d;
      turn_len_q    <= turn_len_d;
      last_tick_q   <= last_tick_d;
      dl_q          <= dl_d;
      dr_q          <= dr_d;
    end
  end

  // A turn can only run on a chosen route.
  a_turn_needs_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    turn_q |-> route_valid_q)
    else $error("turn active without a chosen route");

  // Stored drives never leave the saturated range.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dl_q != -9'sd256) && (dr_q != -9'sd256))
    else $error("drive outside the saturated range");

  // A chosen route always refers to a stored route.
  a_route_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    route_valid_q |-> ({1'b0, route_q} < ROUTE_LIMIT))
    else $error("chosen route beyond the route table");

endmodule

// File: design/lfrc_res_fifo.sv
// Result queue of the line-follow route controller: takes one or two results a cycle
// and hands them out one per transfer. Depends on lfrc_pkg for res_t and its depth.
module lfrc_res_fifo
  import lfrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_two_i,
  input  res_t d0_i,
  input  res_t d1_i,
  output logic room_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  localparam int unsigned DEPTH = RES_FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] push_n;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = push_i ? (push_two_i ? CNT_W'(2) : CNT_W'(1)) : '0;
  assign wr_d        = wr_q + push_n[PTR_W-1:0];
  assign rd_d        = rd_q + PTR_W'(pop);
  assign cnt_d       = cnt_q + push_n - CNT_W'(pop);
  assign room_o      = cnt_q <= CNT_W'(DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= d0_i;
      if (push_two_i) begin
        mem_q[wr_q + PTR_W'(1)] <= d1_i;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  // The step logic only fires when two free places are guaranteed.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("results pushed without room");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("fill count lost a transfer");

endmodule
